### hdl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = AW + 1;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_VIEW   = 2'd1,
        ACT_POP    = 2'd2,
        ACT_REMOVE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SEARCH,
        S_SHIFT,
        S_VIEW
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] task_id;
        logic [7:0]  task_priority;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] entry_id;
        logic [7:0]  entry_priority;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  pri;
    } t_entry;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_entry        wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage

### hdl/spq_store.sv
module spq_store
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/spq_seq.sv
module spq_seq
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_item    i_item,
    input  t_entry   i_rd_data,
    output t_mem_req o_req,
    output logic     o_busy,
    output logic     o_res_valid,
    output t_result  o_res
);

    t_state        r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_tid, n_tid;
    logic [7:0]    r_tpr, n_tpr;
    logic          r_pop, n_pop;

    logic [CW-1:0] idx_inc;
    logic          at_end;
    logic          hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx <= n_idx;
        r_tid <= n_tid;
        r_tpr <= n_tpr;
        r_pop <= n_pop;
    end

    // shared compare unit: position against fill level, key against stored entry
    assign idx_inc = CW'(r_idx) + CW'(1);
    assign at_end  = (idx_inc == r_count);
    assign hit     = r_pop || (i_rd_data.id == r_tid);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_tid       = r_tid;
        n_tpr       = r_tpr;
        n_pop       = r_pop;
        o_req.we    = 1'b0;
        o_req.waddr = r_idx;
        o_req.wdata = i_rd_data;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_OK, entry_id: '0, entry_priority: '0, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_tid = i_item.task_id;
                    n_tpr = i_item.task_priority;
                    n_pop = (i_item.action == ACT_POP);
                    if (i_item.action == ACT_ADD) begin
                        if (r_count == CW'(DEPTH)) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_FULL;
                        end else begin
                            n_state = S_ADD;
                            n_idx   = r_count[AW-1:0];
                        end
                    end else if (r_count == '0) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_EMPTY;
                    end else begin
                        n_state = (i_item.action == ACT_VIEW) ? S_VIEW : S_SEARCH;
                        n_idx   = '0;
                    end
                end
            end
            S_ADD: begin
                // walk from the tail, moving lower-priority entries down one slot
                o_req.we = 1'b1;
                if (r_idx == '0 || i_rd_data.pri >= r_tpr) begin
                    o_req.wdata = '{id: r_tid, pri: r_tpr};
                    o_res_valid = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx - AW'(1);
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    o_res_valid          = 1'b1;
                    o_res.entry_id       = i_rd_data.id;
                    o_res.entry_priority = i_rd_data.pri;
                    n_state              = S_SHIFT;
                end else if (at_end) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = idx_inc[AW-1:0];
                end
            end
            S_SHIFT: begin
                // close the gap: pull each following entry up one slot
                if (at_end) begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end else begin
                    o_req.we = 1'b1;
                    n_idx    = idx_inc[AW-1:0];
                end
            end
            S_VIEW: begin
                o_res_valid          = 1'b1;
                o_res.entry_id       = i_rd_data.id;
                o_res.entry_priority = i_rd_data.pri;
                o_res.last           = at_end;
                if (at_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = idx_inc[AW-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // issue the read for the entry the next step looks at
        unique case (n_state)
            S_ADD:   o_req.raddr = n_idx - AW'(1);
            S_SHIFT: o_req.raddr = n_idx + AW'(1);
            default: o_req.raddr = n_idx;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/sorted_priority_task_queue_top.sv
// Sorted priority task queue: holds up to DEPTH tasks (id, priority) in order of
// descending priority, first in, first out among equal priorities.
//
// Command channel: an item beat is taken on a rising edge with start high and
// busy low. Result channel: o_strobe marks each result beat for one cycle; the
// receiver cannot stall it. o_result.last marks the final beat of a command.
//
// Sequence of each command, with P the slot concerned:
//   add when full, or pop/remove/view when empty: result in the cycle after accept.
//   add: busy while the entries behind slot P move down one slot; the result follows.
//   pop/remove: result once slot P is found (not found: after the last entry), then busy
//   until the gap is closed.
//   view: one entry per cycle from the head, last set on the final entry.
// The sequencer walks the entry store, with its single read and write port, one
// slot a cycle.
//
// Reset empties the queue and clears busy and o_strobe; no clearing pass is run.
module sorted_priority_task_queue_top
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    t_mem_req mem_req;
    t_entry   rd_data;
    logic     res_valid;
    t_result  res;

    logic     r_strobe;
    t_result  r_result;

    spq_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    spq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_item      (i_item),
        .i_rd_data   (rd_data),
        .o_req       (mem_req),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register: hold each result beat for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_valid;
        end
        if (res_valid) begin
            r_result <= res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### hdl/spq_chk.sv
module spq_chk
    import spq_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_strobe && !busy))
        else $error("strobe or busy set straight after reset");

    a_accept_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted command neither busy nor answered");

    a_view_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy ##1 o_strobe)
        else $error("listing beat without a following beat");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |->
            (o_result.last && o_result.entry_id == '0 && o_result.entry_priority == '0))
        else $error("error result not a single blank last beat");

endmodule

bind sorted_priority_task_queue_top spq_chk u_spq_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

### dv/sorted_priority_task_queue_top_tb.sv
module sorted_priority_task_queue_top_tb
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_CMDS = 83;

    typedef struct {
        t_entry slot [DEPTH];
        int     fill;
    } t_task_store;

    typedef struct {
        t_item item;
        bit    hold;    // wait for every outstanding result beat first
    } t_command;

    logic    i_clk;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_strobe;
    t_result o_result;

    t_task_store plan_store;
    t_task_store model_store;
    t_command    plan_q [$];
    t_result     due_results [$];
    t_result     scratch [$];
    int          beats_due = 0;
    int          cmds_taken = 0;
    int          stall_cycles = 0;
    int          errors = 0;

    sorted_priority_task_queue_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Apply one command to a store and append the result beats it produces.
    function automatic void apply_command(ref t_task_store st, input t_item it,
                                          ref t_result beats [$]);
        int      pos;
        int      i;
        t_result r;
        r.status         = ST_OK;
        r.entry_id       = '0;
        r.entry_priority = '0;
        r.last           = 1'b1;
        if (it.action == ACT_ADD) begin
            if (st.fill >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // go behind every entry of greater or equal priority
                pos = 0;
                while (pos < st.fill && st.slot[pos].pri >= it.task_priority)
                    pos++;
                for (i = st.fill; i > pos; i--)
                    st.slot[i] = st.slot[i - 1];
                st.slot[pos].id  = it.task_id;
                st.slot[pos].pri = it.task_priority;
                st.fill++;
            end
            beats.push_back(r);
        end else if (st.fill == 0) begin
            r.status = ST_EMPTY;
            beats.push_back(r);
        end else if (it.action == ACT_VIEW) begin
            for (i = 0; i < st.fill; i++) begin
                r.entry_id       = st.slot[i].id;
                r.entry_priority = st.slot[i].pri;
                r.last           = (i == st.fill - 1);
                beats.push_back(r);
            end
        end else begin
            // pop takes the head, remove the match nearest the head
            pos = 0;
            if (it.action == ACT_REMOVE) begin
                while (pos < st.fill && st.slot[pos].id != it.task_id)
                    pos++;
            end
            if (pos >= st.fill) begin
                r.status = ST_NOTFOUND;
            end else begin
                r.entry_id       = st.slot[pos].id;
                r.entry_priority = st.slot[pos].pri;
                for (i = pos; i < st.fill - 1; i++)
                    st.slot[i] = st.slot[i + 1];
                st.fill--;
            end
            beats.push_back(r);
        end
    endfunction

    function automatic void queue_command(input t_action act, input logic [15:0] id,
                                          input logic [7:0] pri, input bit hold);
        t_command c;
        c.item.action        = act;
        c.item.task_id       = id;
        c.item.task_priority = pri;
        c.hold               = hold;
        scratch.delete();
        apply_command(plan_store, c.item, scratch);
        plan_q.push_back(c);
    endfunction

    always @(posedge i_clk) begin : driver
        t_result fresh [$];
        bit      took;
        bit      pause;
        int      due_next;
        if (!i_rst_n) begin
            start           <= 1'b0;
            beats_due       <= 0;
            model_store.fill = 0;
        end else begin
            took = start && !busy;
            fresh.delete();
            if (took) begin
                apply_command(model_store, i_item, fresh);
                cmds_taken <= cmds_taken + 1;
            end
            foreach (fresh[k])
                due_results.push_back(fresh[k]);
            due_next = beats_due + fresh.size() - (o_strobe ? 1 : 0);
            beats_due <= due_next;
            if (took || !start) begin
                // no idling through the middle of the random run
                pause = (cmds_taken < 60 || cmds_taken >= 100)
                        && ($urandom_range(0, 99) < 8);
                if (plan_q.size() != 0 && !pause && (!plan_q[0].hold || due_next == 0)) begin
                    start  <= 1'b1;
                    i_item <= plan_q[0].item;
                    void'(plan_q.pop_front());
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected: status %0d id %h pri %h last %b",
                       o_result.status, o_result.entry_id, o_result.entry_priority,
                       o_result.last);
                errors++;
            end else begin
                want = due_results.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    errors++;
                end
                if (o_result.entry_id !== want.entry_id) begin
                    $error("entry_id: expected %h, got %h", want.entry_id, o_result.entry_id);
                    errors++;
                end
                if (o_result.entry_priority !== want.entry_priority) begin
                    $error("entry_priority: expected %h, got %h",
                           want.entry_priority, o_result.entry_priority);
                    errors++;
                end
                if (o_result.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_result.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_priority_task_queue_top_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int          n;
        int unsigned roll;
        bit          grow;
        bit          hold;
        t_action     act;
        logic [15:0] id;
        logic [7:0]  pri;

        plan_store.fill = 0;

        // empty queue
        queue_command(ACT_VIEW,   16'h0000, 8'h00, 1'b0);
        queue_command(ACT_POP,    16'h0000, 8'h00, 1'b0);
        queue_command(ACT_REMOVE, 16'hFFFF, 8'hFF, 1'b0);
        // ordering, equal priorities and a duplicate id
        queue_command(ACT_ADD,    16'hFFFF, 8'h00, 1'b0);
        queue_command(ACT_ADD,    16'h0000, 8'hFF, 1'b0);
        queue_command(ACT_ADD,    16'h0000, 8'h80, 1'b0);
        queue_command(ACT_ADD,    16'h5555, 8'hFF, 1'b0);
        queue_command(ACT_REMOVE, 16'h1234, 8'h00, 1'b0);
        queue_command(ACT_REMOVE, 16'h0000, 8'h00, 1'b0);
        queue_command(ACT_VIEW,   16'hAAAA, 8'h55, 1'b0);
        queue_command(ACT_POP,    16'h0000, 8'h00, 1'b0);
        // fill up, overflow, then list a full queue once everything has drained
        for (n = 0; plan_store.fill < DEPTH; n++)
            queue_command(ACT_ADD, 16'($urandom), 8'(n * 17), 1'b0);
        queue_command(ACT_ADD,  16'hFFFF, 8'hFF, 1'b0);
        queue_command(ACT_VIEW, 16'h0000, 8'h00, 1'b1);

        grow = 1'b0;
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (plan_store.fill == DEPTH)
                grow = 1'b0;
            else if (plan_store.fill == 0)
                grow = 1'b1;
            roll = $urandom_range(0, 99);
            hold = (n % 30 == 29);
            if (grow)
                act = roll < 60 ? ACT_ADD : roll < 70 ? ACT_VIEW : roll < 85 ? ACT_POP : ACT_REMOVE;
            else
                act = roll < 15 ? ACT_ADD : roll < 25 ? ACT_VIEW : roll < 60 ? ACT_POP : ACT_REMOVE;
            id  = 16'($urandom);
            pri = 8'($urandom);
            // favour a few priorities so that ties are common
            if ($urandom_range(0, 1) == 0)
                pri = 8'($urandom_range(0, 3) * 85);
            // reuse stored ids: hits for remove, duplicates for add
            if (plan_store.fill != 0) begin
                if ((act == ACT_REMOVE && $urandom_range(0, 3) != 0)
                        || (act == ACT_ADD && $urandom_range(0, 3) == 0))
                    id = plan_store.slot[$urandom_range(0, plan_store.fill - 1)].id;
            end
            queue_command(act, id, pri, hold);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (plan_q.size() != 0 || start || beats_due != 0);
        repeat (DEPTH + 8) @(negedge i_clk);

        if (errors == 0)
            $display("sorted_priority_task_queue_top_tb: PASS");
        else
            $display("sorted_priority_task_queue_top_tb: FAIL");
        $finish;
    end

endmodule
